### src/owhfd_pkg.sv
// Shared types and constants of the single-wire humidity frame decoder.
`default_nettype none

package owhfd_pkg;

    localparam int FRAME_BITS      = 40;
    localparam int CNT_W           = 6;
    localparam int THR_W           = 16;

    localparam logic [CNT_W-1:0] PREAMBLE_EDGES = 6'd2;
    localparam logic [CNT_W-1:0] FRAME_EDGES    = 6'd42;
    localparam logic [CNT_W-1:0] COUNTER_MAX    = 6'd63;
    localparam logic [CNT_W-1:0] LAST_BIT_EDGE  = 6'd41;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd100;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_EDGE   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EDGE_CNT  = 2'd1;
    localparam logic [1:0] ST_CHECKSUM  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] interval_us;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        humidity;
        logic signed [15:0] temperature;
    } t_out_item;

endpackage

`default_nettype wire

### src/one_wire_humidity_frame_decoder.sv
// Top level of the single-wire humidity frame decoder.
// Throughput: one item per cycle while no finish item waits on a stalled output;
// a finish item passes the input register, then the result register, the only stages.
// Start and edge items give no result; only the result register can stall the input.
// Reset (synchronous, active low) clears the edge counter, frame store and valid flags,
// and loads the threshold register with 100.
`default_nettype none

module one_wire_humidity_frame_decoder (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire owhfd_pkg::t_in_item i_in_item,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output owhfd_pkg::t_out_item  o_out_item,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [owhfd_pkg::THR_W-1:0] i_cfg_data
);

    logic                             r_in_valid;
    owhfd_pkg::t_in_item              r_in;
    logic [owhfd_pkg::THR_W-1:0]      r_thr;
    logic [owhfd_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [owhfd_pkg::FRAME_BITS-1:0] r_frame, n_frame;
    logic                             r_out_valid;
    owhfd_pkg::t_out_item             r_out, n_out;

    logic                             out_free;
    logic                             adv;
    logic [owhfd_pkg::CNT_W-1:0]      bit_idx;
    logic [7:0]                       b0, b1, b2, b3, b4, sum;
    logic [14:0]                      mag;

    assign out_free    = !r_out_valid || i_out_ready;
    assign adv         = r_in_valid && (r_in.operation != owhfd_pkg::OP_FINISH || out_free);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign b0 = r_frame[39:32];
    assign b1 = r_frame[31:24];
    assign b2 = r_frame[23:16];
    assign b3 = r_frame[15:8];
    assign b4 = r_frame[7:0];
    assign sum = b0 + b1 + b2 + b3;
    assign mag = {b2[6:0], b3};
    // frame bit for edge n sits at position 41 - n (MSB first)
    assign bit_idx = owhfd_pkg::LAST_BIT_EDGE - r_cnt;

    always_comb begin
        n_cnt   = r_cnt;
        n_frame = r_frame;
        n_out   = '0;
        case (r_in.operation)
            owhfd_pkg::OP_START: begin
                n_cnt   = '0;
                n_frame = '0;
            end
            owhfd_pkg::OP_EDGE: begin
                if (r_cnt >= owhfd_pkg::PREAMBLE_EDGES && r_cnt < owhfd_pkg::FRAME_EDGES
                        && r_in.interval_us > r_thr) begin
                    n_frame[bit_idx] = 1'b1;
                end
                if (r_cnt != owhfd_pkg::COUNTER_MAX) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            owhfd_pkg::OP_FINISH: begin
                if (r_cnt != owhfd_pkg::FRAME_EDGES) begin
                    n_out.status = owhfd_pkg::ST_EDGE_CNT;
                end else if (sum != b4) begin
                    n_out.status = owhfd_pkg::ST_CHECKSUM;
                end else begin
                    n_out.status   = owhfd_pkg::ST_OK;
                    n_out.humidity = {b0, b1};
                    n_out.temperature = b2[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_frame     <= '0;
            r_thr       <= owhfd_pkg::THRESHOLD_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
                r_in       <= i_in_item;
            end
            if (adv) begin
                r_cnt   <= n_cnt;
                r_frame <= n_frame;
            end
            if (adv && r_in.operation == owhfd_pkg::OP_FINISH) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### src/owhfd_checker.sv
// Port-level assertions for the single-wire humidity frame decoder, with bind.
`default_nettype none

module owhfd_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_out_valid,
    input wire                  i_out_ready,
    input wire owhfd_pkg::t_out_item o_out_item
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_error_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != owhfd_pkg::ST_OK)
            |-> (o_out_item.humidity == 16'd0 && o_out_item.temperature == 16'sd0))
        else $error("error result carries nonzero data");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind one_wire_humidity_frame_decoder owhfd_checker u_owhfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire
